@@ src/memory_card_command_responder_defines.svh @@
// assertion helpers for the memory card command responder
`ifndef MEMORY_CARD_COMMAND_RESPONDER_DEFINES_SVH
`define MEMORY_CARD_COMMAND_RESPONDER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MCR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mcr assertion failed");
`define MCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mcr assertion failed");
`else
`define MCR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MCR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ src/mcr_pkg.sv @@
package mcr_pkg;

    typedef struct packed {
        logic        action;
        logic [31:0] packet_word;
        logic        packet_end;
    } t_cmd_in;

    typedef struct packed {
        logic [31:0] response_word;
        logic        response_last;
        logic        response_empty;
        logic        store_dirty;
    } t_resp_out;

    typedef struct packed {
        logic [7:0] root_block;
        logic [7:0] fat_block;
        logic [7:0] directory_block;
        logic [7:0] directory_length;
        logic [7:0] save_area_value;
    } t_geom;

    typedef struct packed {
        logic [7:0]  cmd;
        logic [7:0]  code;
        logic [31:0] fn;
        logic [31:0] block_id;
    } t_resp_ctx;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_EXEC   = 4'b0100,
        ST_COMMIT = 4'b1000
    } t_state;

    localparam logic [2:0] CFG_RESPONSE_LIMIT   = 3'd0;
    localparam logic [2:0] CFG_ROOT_BLOCK       = 3'd1;
    localparam logic [2:0] CFG_FAT_BLOCK        = 3'd2;
    localparam logic [2:0] CFG_DIRECTORY_BLOCK  = 3'd3;
    localparam logic [2:0] CFG_DIRECTORY_LENGTH = 3'd4;
    localparam logic [2:0] CFG_SAVE_AREA_VALUE  = 3'd5;

    localparam logic [31:0] FN_STORAGE = 32'h0200_0000;
    localparam logic [31:0] FN_DISPLAY = 32'h0400_0000;
    localparam logic [31:0] FN_CLOCK   = 32'h0800_0000;

    localparam logic [7:0] OP_INFO    = 8'd1;
    localparam logic [7:0] OP_COND    = 8'd9;
    localparam logic [7:0] OP_GEOM    = 8'd10;
    localparam logic [7:0] OP_READ    = 8'd11;
    localparam logic [7:0] OP_WRITE   = 8'd12;
    localparam logic [7:0] OP_SYNC    = 8'd13;
    localparam logic [7:0] OP_SETCOND = 8'd14;

    localparam logic [7:0] RC_INFO   = 8'h05;
    localparam logic [7:0] RC_OK     = 8'h07;
    localparam logic [7:0] RC_DATA   = 8'h08;
    localparam logic [7:0] RC_BADFN  = 8'hFE;
    localparam logic [7:0] RC_BADOP  = 8'hFD;
    localparam logic [7:0] RC_BADBLK = 8'hFB;

    localparam logic [7:0]  INFO_WORDS = 8'd28;
    localparam logic [31:0] COND_WORD  = 32'h0000_00FF;
    localparam logic [31:0] DATE_WORD0 = 32'h0909_07CF;
    localparam logic [31:0] DATE_WORD1 = 32'h0309_0909;

    function automatic logic [31:0] info_word(input logic [4:0] idx);
        logic [31:0] w;
        case (idx)
            5'd0:  w = 32'h0E00_0000;
            5'd1:  w = 32'h403F_7E7E;
            5'd2:  w = 32'h0010_0500;
            5'd3:  w = 32'h0041_0F00;
            5'd4:  w = 32'h6956_00FF;
            5'd5:  w = 32'h6C61_7573;
            5'd6:  w = 32'h6D65_4D20;
            5'd7:  w = 32'h2079_726F;
            5'd8:  w = 32'h2020_2020;
            5'd9:  w = 32'h2020_2020;
            5'd10: w = 32'h2020_2020;
            5'd11: w = 32'h2020_2020;
            5'd12: w = 32'h646F_7250;
            5'd13: w = 32'h6465_6375;
            5'd14: w = 32'h2079_4220;
            5'd15: w = 32'h5520_726F;
            5'd16: w = 32'h7265_646E;
            5'd17: w = 32'h6369_4C20;
            5'd18: w = 32'h6573_6E65;
            5'd19: w = 32'h6F72_4620;
            5'd20: w = 32'h4553_206D;
            5'd21: w = 32'h4520_4147;
            5'd22: w = 32'h5245_544E;
            5'd23: w = 32'h5349_5250;
            5'd24: w = 32'h4C2C_5345;
            5'd25: w = 32'h202E_4454;
            5'd26: w = 32'h2020_2020;
            5'd27: w = 32'h0082_007C;
            default: w = 32'h0000_0000;
        endcase
        return w;
    endfunction

endpackage

@@ src/mcr_ram.sv @@
module mcr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/mcr_resp_fmt.sv @@
module mcr_resp_fmt import mcr_pkg::*; #(
    parameter int BLOCK_COUNT = 256
) (
    input  t_resp_ctx   i_ctx,
    input  t_geom       i_geom,
    input  logic [7:0]  i_k,
    output logic [31:0] o_word,
    output logic        o_use_mem
);

    localparam logic [31:0] GEOM_LAST = 32'((BLOCK_COUNT - 1) & 32'hFFFF);

    always_comb begin
        o_word    = 32'h0;
        o_use_mem = 1'b0;
        if (i_ctx.code == RC_INFO) begin
            o_word = (i_k < INFO_WORDS) ? info_word(i_k[4:0]) : 32'h0;
        end else if (i_k == 8'd0) begin
            o_word = i_ctx.fn;
        end else if (i_ctx.cmd == OP_COND) begin
            o_word = COND_WORD;
        end else if (i_ctx.cmd == OP_GEOM) begin
            case (i_k)
                8'd1: o_word = GEOM_LAST;
                8'd2: o_word = {8'h0, i_geom.fat_block, 8'h0, i_geom.root_block};
                8'd3: o_word = {8'h0, i_geom.directory_block, 16'h1};
                8'd4: o_word = {24'h0, i_geom.directory_length};
                8'd5: o_word = {16'd31, 8'h0, i_geom.save_area_value};
                default: o_word = 32'h0;
            endcase
        end else if (i_ctx.cmd == OP_READ) begin
            if (i_ctx.fn == FN_CLOCK) begin
                case (i_k)
                    8'd1: o_word = DATE_WORD0;
                    8'd2: o_word = DATE_WORD1;
                    default: o_word = 32'h0;
                endcase
            end else if (i_k == 8'd1) begin
                o_word = i_ctx.block_id;
            end else begin
                o_use_mem = 1'b1;
            end
        end
    end

endmodule

@@ src/memory_card_command_responder.sv @@
// Command responder for a block-structured memory card. Packet words and
// response fetches are items on one command channel: start is taken when busy
// is low, and a fetch returns its word in the next cycle on o_valid, which the
// receiver cannot stall. Packet words and fetches are taken back to back; the
// final word of a packet makes the block busy for command decode, and a valid
// phase write keeps it busy longer while the staged quarter block is copied
// into the store, one word per cycle over the store's single write port.
// After reset the block stays busy while the card store is cleared one word
// per cycle; configuration writes are taken throughout.
`include "memory_card_command_responder_defines.svh"

module memory_card_command_responder import mcr_pkg::*; #(
    parameter int BLOCK_COUNT = 256,
    parameter int BLOCK_BYTES = 512
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_cmd_in   i_cmd,
    output logic      o_valid,
    output t_resp_out o_result,
    input  logic      i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    localparam int BLOCK_WORDS = BLOCK_BYTES / 4;
    localparam int PHASE_WORDS = BLOCK_BYTES / 16;
    localparam int STORE_WORDS = BLOCK_COUNT * BLOCK_WORDS;
    localparam int SA = $clog2(STORE_WORDS);
    localparam int PA = $clog2(PHASE_WORDS);
    localparam int CNT_SAT = 3 + PHASE_WORDS;
    localparam int CW = $clog2(CNT_SAT + 1);
    localparam int SW = $clog2(PHASE_WORDS + 1);

    t_state r_state, n_state;

    logic [31:0] r_header, r_fn, r_bid;
    logic [CW-1:0] r_cnt;
    logic [7:0] r_code, r_len, r_ptr;
    logic r_pending, r_dirty;
    logic [7:0] r_limit;
    t_geom r_geom;
    logic [SA-1:0] r_clr, r_wbase, r_rbase;
    logic [SW-1:0] r_sw;
    logic r_wr_v;
    logic [PA-1:0] r_wr_off;

    logic r_o_valid, r_o_last, r_o_empty, r_o_dirty, r_o_use_mem;
    logic [31:0] r_o_word;

    logic acc, acc_pkt, acc_fetch;
    logic [7:0] cmd;
    logic [15:0] blk;
    logic [7:0] ph;
    logic blk_ok;
    logic [7:0] ex_code;
    logic [31:0] ex_n;
    logic ex_commit, ex_sync;

    t_resp_ctx ctx;
    logic [31:0] fmt_word;
    logic fmt_use_mem;
    logic [7:0] fmt_k;

    logic st_we;
    logic [SA-1:0] st_waddr, st_raddr;
    logic [31:0] st_wdata, st_rdata;
    logic stg_we;
    logic [PA-1:0] stg_waddr;
    logic [31:0] stg_rdata;

    assign busy      = (r_state != ST_IDLE);
    assign acc       = start && !busy;
    assign acc_pkt   = acc && !i_cmd.action;
    assign acc_fetch = acc && i_cmd.action;

    assign cmd    = r_header[7:0];
    assign blk    = {r_bid[23:16], r_bid[31:24]};
    assign ph     = r_bid[15:8];
    assign blk_ok = 32'(blk) < BLOCK_COUNT;

    // command decode
    always_comb begin
        ex_code   = RC_BADOP;
        ex_n      = 32'd0;
        ex_commit = 1'b0;
        ex_sync   = 1'b0;
        case (cmd)
            OP_INFO: begin
                ex_code = RC_INFO;
                ex_n    = 32'(INFO_WORDS);
            end
            OP_COND: begin
                if (r_fn == FN_CLOCK) begin
                    ex_code = RC_DATA;
                    ex_n    = 32'd2;
                end else begin
                    ex_code = RC_BADFN;
                end
            end
            OP_GEOM: begin
                if (r_fn == FN_STORAGE) begin
                    ex_code = RC_DATA;
                    ex_n    = 32'd7;
                end else begin
                    ex_code = RC_BADFN;
                end
            end
            OP_READ: begin
                if (r_fn == FN_STORAGE) begin
                    if (!blk_ok || ph != 8'd0) begin
                        ex_code = RC_BADBLK;
                    end else begin
                        ex_code = RC_DATA;
                        ex_n    = 32'(2 + BLOCK_WORDS);
                    end
                end else if (r_fn == FN_CLOCK) begin
                    ex_code = RC_DATA;
                    ex_n    = 32'd3;
                end else begin
                    ex_code = RC_BADFN;
                end
            end
            OP_WRITE: begin
                if (r_fn == FN_STORAGE) begin
                    if (!blk_ok || ph >= 8'd4 || 32'(r_cnt) < CNT_SAT) begin
                        ex_code = RC_BADBLK;
                    end else begin
                        ex_code   = RC_OK;
                        ex_commit = 1'b1;
                    end
                end else if (r_fn == FN_DISPLAY || r_fn == FN_CLOCK) begin
                    ex_code = RC_OK;
                end else begin
                    ex_code = RC_BADFN;
                end
            end
            OP_SYNC: begin
                ex_code = RC_OK;
                ex_sync = 1'b1;
            end
            OP_SETCOND: begin
                ex_code = RC_OK;
            end
            default: begin
                ex_code = RC_BADOP;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == SA'(STORE_WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (acc_pkt && i_cmd.packet_end) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ex_commit ? ST_COMMIT : ST_IDLE;
            end
            ST_COMMIT: begin
                if (r_sw == SW'(PHASE_WORDS)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    assign ctx   = '{cmd: cmd, code: r_code, fn: r_fn, block_id: r_bid};
    assign fmt_k = r_ptr - 8'd1;

    mcr_resp_fmt #(
        .BLOCK_COUNT(BLOCK_COUNT)
    ) u_fmt (
        .i_ctx    (ctx),
        .i_geom   (r_geom),
        .i_k      (fmt_k),
        .o_word   (fmt_word),
        .o_use_mem(fmt_use_mem)
    );

    // store: clearing pass or commit on the write side, fetch on the read side
    assign st_we    = (r_state == ST_CLEAR) || r_wr_v;
    assign st_waddr = (r_state == ST_CLEAR) ? r_clr : r_wbase + SA'(r_wr_off);
    assign st_wdata = (r_state == ST_CLEAR) ? 32'h0 : stg_rdata;
    assign st_raddr = r_rbase + SA'(r_ptr) - SA'(3);

    mcr_ram #(
        .WIDTH(32),
        .DEPTH(STORE_WORDS)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (st_we),
        .i_waddr(st_waddr),
        .i_wdata(st_wdata),
        .i_raddr(st_raddr),
        .o_rdata(st_rdata)
    );

    assign stg_we    = acc_pkt && 32'(r_cnt) >= 3 && 32'(r_cnt) < CNT_SAT;
    assign stg_waddr = PA'(r_cnt - CW'(3));

    mcr_ram #(
        .WIDTH(32),
        .DEPTH(PHASE_WORDS)
    ) u_staging (
        .i_clk  (i_clk),
        .i_we   (stg_we),
        .i_waddr(stg_waddr),
        .i_wdata(i_cmd.packet_word),
        .i_raddr(r_sw[PA-1:0]),
        .o_rdata(stg_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_header  <= '0;
            r_fn      <= '0;
            r_bid     <= '0;
            r_cnt     <= '0;
            r_code    <= '0;
            r_len     <= '0;
            r_ptr     <= '0;
            r_pending <= 1'b0;
            r_dirty   <= 1'b0;
            r_limit   <= 8'd255;
            r_geom    <= '{root_block: 8'd255, fat_block: 8'd254, directory_block: 8'd253,
                           directory_length: 8'd13, save_area_value: 8'd200};
            r_clr     <= '0;
            r_sw      <= '0;
            r_wr_v    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= acc_fetch;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_RESPONSE_LIMIT:   r_limit                 <= i_cfg_data;
                    CFG_ROOT_BLOCK:       r_geom.root_block       <= i_cfg_data;
                    CFG_FAT_BLOCK:        r_geom.fat_block        <= i_cfg_data;
                    CFG_DIRECTORY_BLOCK:  r_geom.directory_block  <= i_cfg_data;
                    CFG_DIRECTORY_LENGTH: r_geom.directory_length <= i_cfg_data;
                    CFG_SAVE_AREA_VALUE:  r_geom.save_area_value  <= i_cfg_data;
                    default: ;
                endcase
            end

            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + SA'(1);
            end

            if (acc_pkt) begin
                if (r_cnt == CW'(0)) begin
                    r_pending <= 1'b0;
                    r_fn      <= '0;
                    r_bid     <= '0;
                    r_header  <= i_cmd.packet_word;
                end else if (r_cnt == CW'(1)) begin
                    r_fn <= i_cmd.packet_word;
                end else if (r_cnt == CW'(2)) begin
                    r_bid <= i_cmd.packet_word;
                end
                if (32'(r_cnt) < CNT_SAT) begin
                    r_cnt <= r_cnt + CW'(1);
                end
            end

            if (r_state == ST_EXEC) begin
                r_cnt     <= '0;
                r_code    <= ex_code;
                r_len     <= ex_n[7:0];
                r_ptr     <= '0;
                r_pending <= (ex_n + 32'd1) <= 32'(r_limit);
                r_sw      <= '0;
                if (ex_sync) begin
                    r_dirty <= 1'b0;
                end
                if (ex_commit) begin
                    r_dirty <= 1'b1;
                end
            end

            if (r_state == ST_COMMIT) begin
                r_sw     <= r_sw + SW'(1);
                r_wr_v   <= r_sw < SW'(PHASE_WORDS);
                r_wr_off <= r_sw[PA-1:0];
            end else begin
                r_wr_v <= 1'b0;
            end

            if (acc_fetch && r_pending) begin
                r_ptr <= r_ptr + 8'd1;
                if (r_ptr >= r_len) begin
                    r_pending <= 1'b0;
                end
            end
        end
    end

    // base addresses and fetch word, payload only
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EXEC) begin
            r_rbase <= SA'(32'(blk) * BLOCK_WORDS);
            r_wbase <= SA'(32'(blk) * BLOCK_WORDS + 32'(ph[1:0]) * PHASE_WORDS);
        end
        if (acc_fetch) begin
            r_o_dirty <= r_dirty;
            if (!r_pending) begin
                r_o_word    <= 32'h0;
                r_o_last    <= 1'b0;
                r_o_empty   <= 1'b1;
                r_o_use_mem <= 1'b0;
            end else begin
                r_o_last  <= r_ptr >= r_len;
                r_o_empty <= 1'b0;
                if (r_ptr == 8'd0) begin
                    r_o_word    <= {r_len, r_header[15:8], r_header[23:16], r_code};
                    r_o_use_mem <= 1'b0;
                end else begin
                    r_o_word    <= fmt_word;
                    r_o_use_mem <= fmt_use_mem;
                end
            end
        end
    end

    assign o_valid                 = r_o_valid;
    assign o_result.response_word  = r_o_use_mem ? st_rdata : r_o_word;
    assign o_result.response_last  = r_o_last;
    assign o_result.response_empty = r_o_empty;
    assign o_result.store_dirty    = r_o_dirty;

    `MCR_ASSERT_NEXT(a_fetch_strobe, i_clk, i_rst_n, acc_fetch, o_valid)
    `MCR_ASSERT_NEXT(a_end_goes_busy, i_clk, i_rst_n, acc_pkt && i_cmd.packet_end, busy)
    `MCR_ASSERT_SAME(a_store_write_owner, i_clk, i_rst_n, st_we,
                     r_state == ST_CLEAR || r_state == ST_COMMIT)
    `MCR_ASSERT_SAME(a_empty_is_blank, i_clk, i_rst_n,
                     o_valid && o_result.response_empty,
                     o_result.response_word == 32'h0 && !o_result.response_last)

endmodule

@@ tb/sv/tb_memory_card_command_responder.sv @@
`timescale 1ns / 100ps

module tb_memory_card_command_responder;
    import mcr_pkg::*;

    localparam int STORE_WORDS = 32768;
    localparam int BLK_WORDS   = 128;
    localparam int PH_WORDS    = 32;
    localparam int MAX_CYCLES  = 600000;

    localparam logic [31:0] DEV_INFO [0:27] = '{
        32'h0E000000, 32'h403F7E7E, 32'h00100500, 32'h00410F00,
        32'h695600FF, 32'h6C617573, 32'h6D654D20, 32'h2079726F,
        32'h20202020, 32'h20202020, 32'h20202020, 32'h20202020,
        32'h646F7250, 32'h64656375, 32'h20794220, 32'h5520726F,
        32'h7265646E, 32'h63694C20, 32'h65736E65, 32'h6F724620,
        32'h4553206D, 32'h45204147, 32'h5245544E, 32'h53495250,
        32'h4C2C5345, 32'h202E4454, 32'h20202020, 32'h0082007C
    };

    typedef struct {
        bit          act;
        logic [31:0] word;
        bit          last_word;
        bit          typed;
        logic [31:0] x_word;
        bit          x_last;
        bit          x_empty;
    } t_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_cmd_in    i_cmd;
    logic       o_valid;
    t_resp_out  o_result;
    logic       i_cfg_we;
    logic [2:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    memory_card_command_responder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // card model state
    logic [31:0] card_mem [0:STORE_WORDS-1];
    logic [31:0] stage [0:PH_WORDS-1];
    logic [31:0] hdr_w, fn_w, id_w;
    int          word_cnt;
    logic [7:0]  resp_code;
    int          resp_len, resp_ptr;
    bit          resp_pend, dirty;
    logic [7:0]  cfg_regs [0:5];

    t_resp_out   resp_q [$];
    int          errs;
    int          cycles;
    int          idle_pct;
    int          n_items;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_resp_out x;
        if (i_rst_n && o_valid) begin
            if (resp_q.size() == 0) begin
                $error("unexpected response transfer %h", o_result);
                errs++;
            end else begin
                x = resp_q.pop_front();
                if (o_result.response_word !== x.response_word) begin
                    $error("response_word exp %h got %h", x.response_word,
                           o_result.response_word);
                    errs++;
                end
                if (o_result.response_last !== x.response_last) begin
                    $error("response_last exp %b got %b", x.response_last,
                           o_result.response_last);
                    errs++;
                end
                if (o_result.response_empty !== x.response_empty) begin
                    $error("response_empty exp %b got %b", x.response_empty,
                           o_result.response_empty);
                    errs++;
                end
                if (o_result.store_dirty !== x.store_dirty) begin
                    $error("store_dirty exp %b got %b", x.store_dirty,
                           o_result.store_dirty);
                    errs++;
                end
            end
        end
    end

    function automatic logic [15:0] blk_of(input logic [31:0] id);
        return {id[23:16], id[31:24]};
    endfunction

    function automatic logic [31:0] resp_data(input int k);
        logic [7:0] cmd;
        int         idx;
        cmd = hdr_w[7:0];
        if (resp_code == RC_INFO)
            return (k < 28) ? DEV_INFO[k] : 32'h0;
        if (k == 0)
            return fn_w;
        if (cmd == OP_COND)
            return COND_WORD;
        if (cmd == OP_GEOM) begin
            case (k)
                1: return 32'h0000_00FF;
                2: return {8'h0, cfg_regs[CFG_FAT_BLOCK], 8'h0, cfg_regs[CFG_ROOT_BLOCK]};
                3: return {8'h0, cfg_regs[CFG_DIRECTORY_BLOCK], 16'h0001};
                4: return {24'h0, cfg_regs[CFG_DIRECTORY_LENGTH]};
                5: return {16'h001F, 8'h0, cfg_regs[CFG_SAVE_AREA_VALUE]};
                default: return 32'h0;
            endcase
        end
        if (cmd == OP_READ) begin
            if (fn_w == FN_CLOCK)
                return (k == 1) ? DATE_WORD0 : (k == 2) ? DATE_WORD1 : 32'h0;
            if (k == 1)
                return id_w;
            idx = (int'(blk_of(id_w)) * BLK_WORDS + k - 2) % STORE_WORDS;
            return card_mem[idx];
        end
        return 32'h0;
    endfunction

    task automatic run_cmd();
        logic [7:0]  cmd;
        logic [15:0] blk;
        logic [7:0]  ph;
        int          n;
        cmd = hdr_w[7:0];
        blk = blk_of(id_w);
        ph  = id_w[15:8];
        n   = 0;
        resp_code = RC_BADOP;
        case (cmd)
            OP_INFO: begin
                resp_code = RC_INFO;
                n = 28;
            end
            OP_COND: begin
                if (fn_w == FN_CLOCK) begin
                    resp_code = RC_DATA;
                    n = 2;
                end else resp_code = RC_BADFN;
            end
            OP_GEOM: begin
                if (fn_w == FN_STORAGE) begin
                    resp_code = RC_DATA;
                    n = 7;
                end else resp_code = RC_BADFN;
            end
            OP_READ: begin
                if (fn_w == FN_STORAGE) begin
                    if (blk >= 256 || ph != 0) resp_code = RC_BADBLK;
                    else begin
                        resp_code = RC_DATA;
                        n = 2 + BLK_WORDS;
                    end
                end else if (fn_w == FN_CLOCK) begin
                    resp_code = RC_DATA;
                    n = 3;
                end else resp_code = RC_BADFN;
            end
            OP_WRITE: begin
                if (fn_w == FN_STORAGE) begin
                    if (blk >= 256 || ph >= 4 || word_cnt < 3 + PH_WORDS)
                        resp_code = RC_BADBLK;
                    else begin
                        for (int i = 0; i < PH_WORDS; i++)
                            card_mem[(int'(blk) * BLK_WORDS + int'(ph) * PH_WORDS + i)
                                     % STORE_WORDS] = stage[i];
                        dirty = 1'b1;
                        resp_code = RC_OK;
                    end
                end else if (fn_w == FN_DISPLAY || fn_w == FN_CLOCK) resp_code = RC_OK;
                else resp_code = RC_BADFN;
            end
            OP_SYNC: begin
                dirty = 1'b0;
                resp_code = RC_OK;
            end
            OP_SETCOND: resp_code = RC_OK;
            default: ;
        endcase
        resp_len  = n;
        resp_ptr  = 0;
        resp_pend = (1 + n) <= int'(cfg_regs[CFG_RESPONSE_LIMIT]);
    endtask

    task automatic predict(input t_cmd_in c, output bit got, output t_resp_out r);
        int cnt;
        bit fin;
        got = 1'b0;
        r   = '0;
        if (!c.action) begin
            cnt = word_cnt;
            if (cnt == 0) begin
                resp_pend = 1'b0;
                fn_w  = 32'h0;
                id_w  = 32'h0;
                hdr_w = c.packet_word;
            end else if (cnt == 1) fn_w = c.packet_word;
            else if (cnt == 2) id_w = c.packet_word;
            else if (cnt - 3 < PH_WORDS) stage[cnt-3] = c.packet_word;
            if (cnt < 16'hFFFF) word_cnt = cnt + 1;
            if (c.packet_end) begin
                run_cmd();
                word_cnt = 0;
            end
        end else begin
            got = 1'b1;
            r.store_dirty = dirty;
            if (!resp_pend) begin
                r.response_empty = 1'b1;
            end else begin
                fin = resp_ptr >= resp_len;
                if (resp_ptr == 0)
                    r.response_word = {resp_len[7:0], hdr_w[15:8], hdr_w[23:16], resp_code};
                else
                    r.response_word = resp_data(resp_ptr - 1);
                r.response_last = fin;
                resp_ptr++;
                if (fin) resp_pend = 1'b0;
            end
            r.store_dirty = dirty;
        end
    endtask

    // called at a falling edge, returns at a falling edge after the transfer
    task automatic drive(input t_cmd_in c, input bit typed, input t_resp_out xr);
        bit        got;
        t_resp_out r;
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        predict(c, got, r);
        if (got) resp_q.push_back(typed ? xr : r);
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic put(input bit act, input logic [31:0] w, input bit fin);
        t_cmd_in c;
        c.action = act;
        c.packet_word = w;
        c.packet_end = fin;
        drive(c, 1'b0, '0);
    endtask

    task automatic send_packet(input logic [31:0] words [$]);
        foreach (words[i])
            put(1'b0, words[i], i == words.size() - 1);
    endtask

    task automatic settle();
        start <= 1'b0;
        @(negedge i_clk);
        while (resp_q.size() != 0 || busy) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [7:0] vals [0:5]);
        for (int i = 0; i < 6; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= i[2:0];
            i_cfg_data  <= vals[i];
            cfg_regs[i] = vals[i];
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_fn(input logic [31:0] pref);
        case ($urandom_range(7))
            0: return FN_STORAGE;
            1: return FN_DISPLAY;
            2: return FN_CLOCK;
            3: return $urandom;
            default: return pref;
        endcase
    endfunction

    function automatic logic [31:0] pick_id(input bit any_phase);
        logic [7:0] lo_blk, hi_blk, ph;
        lo_blk = ($urandom_range(9) < 7) ? 8'($urandom_range(7)) : 8'($urandom);
        hi_blk = ($urandom_range(9) < 9) ? 8'h00 : 8'($urandom);
        if (any_phase) ph = ($urandom_range(9) < 9) ? 8'($urandom_range(3)) : 8'($urandom);
        else ph = ($urandom_range(9) < 9) ? 8'h00 : 8'($urandom);
        return {lo_blk, hi_blk, ph, 8'($urandom)};
    endfunction

    task automatic random_traffic(input int budget);
        logic [31:0] pkt [$];
        logic [31:0] hdr;
        logic [7:0]  cmd;
        int          kind, nd, nf;
        int          stop_at;
        stop_at = n_items + budget;
        while (n_items < stop_at) begin
            kind = $urandom_range(12);
            pkt.delete();
            case (kind)
                0: cmd = OP_INFO;
                1: cmd = OP_COND;
                2: cmd = OP_GEOM;
                3, 4, 5: cmd = OP_READ;
                6, 7, 8, 9: cmd = OP_WRITE;
                10: cmd = OP_SYNC;
                11: cmd = OP_SETCOND;
                default: cmd = 8'($urandom);
            endcase
            hdr = {8'($urandom), 8'($urandom), 8'($urandom), cmd};
            pkt.push_back(hdr);
            case (kind)
                0, 10, 11: if ($urandom_range(3) == 0) pkt.push_back($urandom);
                1: pkt.push_back(pick_fn(FN_CLOCK));
                2: pkt.push_back(pick_fn(FN_STORAGE));
                3, 4: begin
                    pkt.push_back(pick_fn(FN_STORAGE));
                    pkt.push_back(pick_id(1'b0));
                end
                5: begin
                    pkt.push_back(pick_fn(FN_CLOCK));
                    if ($urandom_range(1)) pkt.push_back(pick_id(1'b0));
                end
                6, 7, 8: begin
                    pkt.push_back(($urandom_range(9) < 9) ? FN_STORAGE : pick_fn(FN_STORAGE));
                    pkt.push_back(pick_id(1'b1));
                    nd = PH_WORDS;
                    if (kind == 8)
                        nd = $urandom_range(1) ? $urandom_range(PH_WORDS - 1)
                                               : PH_WORDS + $urandom_range(1, 6);
                    repeat (nd) pkt.push_back($urandom);
                end
                9: begin
                    pkt.push_back(pick_fn(FN_DISPLAY));
                    pkt.push_back($urandom);
                    repeat ($urandom_range(3)) pkt.push_back($urandom);
                end
                default: repeat ($urandom_range(3)) pkt.push_back($urandom);
            endcase
            send_packet(pkt);
            nf = resp_pend ? resp_len + 1 : 1;
            if ($urandom_range(99) < 15) nf = $urandom_range(nf);
            else nf = nf + $urandom_range(1);
            repeat (nf) put(1'b1, $urandom, 1'($urandom));
        end
    endtask

    t_row rows [0:26] = '{
        '{1, 32'h0, 0, 1, 32'h00000000, 0, 1},
        '{0, 32'h00012001, 1, 0, 32'h0, 0, 0},
        '{1, 32'h0, 0, 1, 32'h1C200105, 0, 0},
        '{1, 32'h0, 0, 1, 32'h0E000000, 0, 0},
        '{1, 32'h0, 0, 1, 32'h403F7E7E, 0, 0},
        // new packet drops the rest of the info transfer
        '{0, 32'hFFFFFFFF, 1, 0, 32'h0, 0, 0},
        '{1, 32'hFFFFFFFF, 1, 1, 32'h00FFFFFD, 1, 0},
        '{1, 32'h0, 0, 1, 32'h00000000, 0, 1},
        '{0, 32'h00000000, 1, 0, 32'h0, 0, 0},
        '{1, 32'h0, 0, 1, 32'h000000FD, 1, 0},
        '{0, 32'h0000000A, 0, 0, 32'h0, 0, 0},
        '{0, 32'h00000000, 1, 0, 32'h0, 0, 0},
        '{1, 32'h0, 0, 1, 32'h000000FE, 1, 0},
        '{0, 32'h0000000B, 0, 0, 32'h0, 0, 0},
        '{0, FN_STORAGE, 0, 0, 32'h0, 0, 0},
        '{0, 32'h00010000, 1, 0, 32'h0, 0, 0},
        '{1, 32'h0, 0, 1, 32'h000000FB, 1, 0},
        '{0, 32'h0000000C, 0, 0, 32'h0, 0, 0},
        '{0, FN_STORAGE, 0, 0, 32'h0, 0, 0},
        '{0, 32'h00000000, 1, 0, 32'h0, 0, 0},
        '{1, 32'h0, 0, 1, 32'h000000FB, 1, 0},
        '{0, 32'h0000000A, 0, 0, 32'h0, 0, 0},
        '{0, FN_STORAGE, 1, 0, 32'h0, 0, 0},
        '{1, 32'h0, 0, 0, 32'h0, 0, 0},
        '{1, 32'h0, 0, 0, 32'h0, 0, 0},
        '{0, 32'h0000000D, 1, 0, 32'h0, 0, 0},
        '{1, 32'h0, 0, 1, 32'h00000007, 1, 0}
    };

    initial begin
        logic [7:0] vals [0:5];
        t_cmd_in    c;
        t_resp_out  xr;
        errs = 0;
        cycles = 0;
        n_items = 0;
        idle_pct = 9;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_RESPONSE_LIMIT;
        i_cfg_data = 8'h0;
        for (int i = 0; i < STORE_WORDS; i++) card_mem[i] = 32'h0;
        for (int i = 0; i < PH_WORDS; i++) stage[i] = 32'h0;
        hdr_w = 0; fn_w = 0; id_w = 0;
        word_cnt = 0; resp_code = 0; resp_len = 0; resp_ptr = 0;
        resp_pend = 0; dirty = 0;
        cfg_regs = '{8'd255, 8'd255, 8'd254, 8'd253, 8'd13, 8'd200};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[i]) begin
            c.action = rows[i].act;
            c.packet_word = rows[i].word;
            c.packet_end = rows[i].last_word;
            xr.response_word = rows[i].x_word;
            xr.response_last = rows[i].x_last;
            xr.response_empty = rows[i].x_empty;
            xr.store_dirty = 1'b0;
            drive(c, rows[i].typed, xr);
        end

        for (int ph = 0; ph < 4; ph++) begin
            settle();
            case (ph)
                0: vals = '{8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
                1: vals = '{8'd8, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
                2: vals = '{8'($urandom_range(132, 255)), 8'($urandom), 8'($urandom),
                             8'($urandom), 8'($urandom), 8'($urandom)};
                default: vals = '{8'd1, 8'($urandom), 8'($urandom), 8'($urandom),
                                  8'($urandom), 8'($urandom)};
            endcase
            write_cfg(vals);
            idle_pct = (ph == 1) ? 68 : (ph >= 2) ? 0 : 9;
            random_traffic(ph == 3 ? 200 : 400);
        end
        settle();

        if (errs == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
